// ===== sv/vsd_pkg.sv =====
`timescale 1ns / 1ps

package vsd_pkg;

    localparam int POS_W      = 32;
    localparam int STEP_W     = 16;
    localparam int DIFF_W     = POS_W + 1;
    localparam int DIVISOR_W  = STEP_W + 1;
    localparam int DIVIDEND_W = DIFF_W + DIVISOR_W;
    localparam int QUO_W      = DIFF_W;
    localparam int DIV_STEPS  = 3;
    localparam int DIV_ITERS  = QUO_W / DIV_STEPS;
    localparam int DIV_CNT_W  = $clog2(DIV_ITERS);
    localparam int CNT_W      = 2;

    localparam logic [POS_W-1:0]  Q_MAX     = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic [POS_W-1:0]  Q_MIN     = {1'b1, {(POS_W-1){1'b0}}};
    localparam logic [STEP_W-1:0] STEP_LSB  = STEP_W'(1);
    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(3);

    typedef enum logic [1:0] {
        PH_VEL = 2'd0,
        PH_ACC = 2'd1,
        PH_JRK = 2'd2
    } t_phase;

    typedef struct packed {
        logic   load;
        logic   div_start;
        t_phase phase;
        logic   wr_res;
        logic   publish;
    } t_cmd;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             div_done;
        logic             out_full;
    } t_stat;

endpackage

// ===== sv/vsd_intf.sv =====
`timescale 1ns / 1ps

interface vsd_in_if import vsd_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [POS_W-1:0]  position;
    logic        [STEP_W-1:0] step_time;
    logic                     restart;

    modport source (output valid, position, step_time, restart, input ready);
    modport sink   (input valid, position, step_time, restart, output ready);
endinterface

interface vsd_out_if import vsd_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] velocity;
    logic signed [POS_W-1:0] acceleration;
    logic signed [POS_W-1:0] jerk;
    logic                    saturated;

    modport source (output valid, velocity, acceleration, jerk, saturated, input ready);
    modport sink   (input valid, velocity, acceleration, jerk, saturated, output ready);
endinterface

// ===== sv/vsd_div.sv =====
`timescale 1ns / 1ps

module vsd_div import vsd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    input  logic                  i_neg,
    output logic                  o_done,
    output logic [POS_W-1:0]      o_result,
    output logic                  o_sat
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIVISOR_W-1:0] r_rem;
    logic [DIVISOR_W-1:0] n_rem;
    logic [QUO_W-1:0]     r_quo;
    logic [QUO_W-1:0]     n_quo;
    logic [DIVISOR_W-1:0] r_div;
    logic                 r_neg;
    logic                 r_ovf;
    logic                 last;
    logic                 pos_sat;
    logic                 neg_sat;

    assign last = (r_cnt == DIV_CNT_W'(DIV_ITERS - 1));

    // restoring steps, remainder stays below the divisor
    always_comb begin
        logic [DIVISOR_W:0]   t;
        logic [DIVISOR_W-1:0] rem;
        logic [QUO_W-1:0]     quo;
        rem = r_rem;
        quo = r_quo;
        for (int k = 0; k < DIV_STEPS; k++) begin
            t = {rem, quo[QUO_W-1]};
            if (t >= {1'b0, r_div}) begin
                quo = {quo[QUO_W-2:0], 1'b1};
                rem = DIVISOR_W'(t - {1'b0, r_div});
            end else begin
                quo = {quo[QUO_W-2:0], 1'b0};
                rem = t[DIVISOR_W-1:0];
            end
        end
        n_rem = rem;
        n_quo = quo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && last;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DIV_CNT_W'(1);
                if (last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[DIVIDEND_W-1:QUO_W];
            r_quo <= i_dividend[QUO_W-1:0];
            r_div <= i_divisor;
            r_neg <= i_neg;
            r_ovf <= (i_dividend[DIVIDEND_W-1:QUO_W] >= i_divisor);
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign pos_sat = r_ovf | (|r_quo[QUO_W-1:POS_W-1]);
    assign neg_sat = r_ovf | r_quo[QUO_W-1] | (r_quo[POS_W-1] & (|r_quo[POS_W-2:0]));

    always_comb begin
        if (r_neg) begin
            o_sat    = neg_sat;
            o_result = neg_sat ? Q_MIN : POS_W'(~r_quo[POS_W-1:0] + POS_W'(1));
        end else begin
            o_sat    = pos_sat;
            o_result = pos_sat ? Q_MAX : r_quo[POS_W-1:0];
        end
    end

    assign o_done = r_done;

endmodule

// ===== sv/vsd_dp.sv =====
`timescale 1ns / 1ps

module vsd_dp import vsd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    input  logic [POS_W-1:0]  i_position,
    input  logic [STEP_W-1:0] i_step_time,
    input  logic              i_restart,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [POS_W-1:0]  o_velocity,
    output logic [POS_W-1:0]  o_acceleration,
    output logic [POS_W-1:0]  o_jerk,
    output logic              o_saturated
);

    logic [POS_W-1:0]      r_pos;
    logic [STEP_W-1:0]     r_step;
    logic [CNT_W-1:0]      r_count;
    logic [POS_W-1:0]      r_vel;
    logic [POS_W-1:0]      r_acc;
    logic [POS_W-1:0]      r_jrk;
    logic                  r_sat;
    logic [POS_W-1:0]      r_prev_pos;
    logic [STEP_W-1:0]     r_prev_step;
    logic [POS_W-1:0]      r_prev_vel;
    logic [POS_W-1:0]      r_prev_acc;
    logic [CNT_W-1:0]      r_sample_count;
    logic                  r_out_valid;
    logic [POS_W-1:0]      r_out_vel;
    logic [POS_W-1:0]      r_out_acc;
    logic [POS_W-1:0]      r_out_jrk;
    logic                  r_out_sat;

    logic [DIFF_W-1:0]     diff;
    logic [DIFF_W-1:0]     mag;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
    logic                  div_done;
    logic [POS_W-1:0]      div_result;
    logic                  div_sat;

    // divider operands for the current derivative
    always_comb begin
        case (i_cmd.phase)
            PH_ACC: begin
                diff    = {r_vel[POS_W-1], r_vel} - {r_prev_vel[POS_W-1], r_prev_vel};
                divisor = {1'b0, r_step} + {1'b0, r_prev_step};
            end
            PH_JRK: begin
                diff    = {r_acc[POS_W-1], r_acc} - {r_prev_acc[POS_W-1], r_prev_acc};
                divisor = {1'b0, (r_prev_step == '0) ? STEP_LSB : r_prev_step};
            end
            default: begin
                diff    = {r_pos[POS_W-1], r_pos} - {r_prev_pos[POS_W-1], r_prev_pos};
                divisor = {1'b0, r_step};
            end
        endcase
        mag      = diff[DIFF_W-1] ? DIFF_W'(~diff + DIFF_W'(1)) : diff;
        dividend = {mag, {DIVISOR_W{1'b0}}};
        if (i_cmd.phase != PH_ACC) begin
            dividend = dividend >> 1;
        end
    end

    vsd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .i_neg      (diff[DIFF_W-1]),
        .o_done     (div_done),
        .o_result   (div_result),
        .o_sat      (div_sat)
    );

    // current word and its results
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pos   <= i_position;
            r_step  <= (i_step_time == '0) ? STEP_LSB : i_step_time;
            r_count <= i_restart ? '0 : r_sample_count;
            r_vel   <= '0;
            r_acc   <= '0;
            r_jrk   <= '0;
            r_sat   <= 1'b0;
        end else if (i_cmd.wr_res) begin
            r_sat <= r_sat | div_sat;
            case (i_cmd.phase)
                PH_ACC:  r_acc <= div_result;
                PH_JRK:  r_jrk <= div_result;
                default: r_vel <= div_result;
            endcase
        end
    end

    // path history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_pos     <= '0;
            r_prev_step    <= '0;
            r_prev_vel     <= '0;
            r_prev_acc     <= '0;
            r_sample_count <= '0;
        end else if (i_cmd.publish) begin
            r_prev_pos     <= r_pos;
            r_prev_step    <= r_step;
            r_prev_vel     <= r_vel;
            r_prev_acc     <= r_acc;
            r_sample_count <= (r_count == CNT_FULL) ? CNT_FULL : r_count + CNT_W'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.publish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_out_vel <= r_vel;
            r_out_acc <= r_acc;
            r_out_jrk <= r_jrk;
            r_out_sat <= r_sat;
        end
    end

    assign o_stat.count    = r_count;
    assign o_stat.div_done = div_done;
    assign o_stat.out_full = r_out_valid && !i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_velocity     = r_out_vel;
    assign o_acceleration = r_out_acc;
    assign o_jerk         = r_out_jrk;
    assign o_saturated    = r_out_sat;

endmodule

// ===== sv/vsd_ctrl.sv =====
`timescale 1ns / 1ps

module vsd_ctrl import vsd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_VEL  = 5'b00010,
        S_ACC  = 5'b00100,
        S_JRK  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_go;
    logic   n_go;

    always_comb begin
        n_state         = r_state;
        n_go            = 1'b0;
        o_cmd.load      = 1'b0;
        o_cmd.div_start = 1'b0;
        o_cmd.wr_res    = 1'b0;
        o_cmd.publish   = 1'b0;
        case (r_state)
            S_ACC:   o_cmd.phase = PH_ACC;
            S_JRK:   o_cmd.phase = PH_JRK;
            default: o_cmd.phase = PH_VEL;
        endcase
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_VEL;
                    n_go       = 1'b1;
                end
            end
            S_VEL: begin
                if (i_stat.count == '0) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.div_start = r_go;
                    if (i_stat.div_done) begin
                        o_cmd.wr_res = 1'b1;
                        if (i_stat.count inside {2'd2, 2'd3}) begin
                            n_state = S_ACC;
                            n_go    = 1'b1;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                end
            end
            S_ACC: begin
                o_cmd.div_start = r_go;
                if (i_stat.div_done) begin
                    o_cmd.wr_res = 1'b1;
                    if (i_stat.count == CNT_FULL) begin
                        n_state = S_JRK;
                        n_go    = 1'b1;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_JRK: begin
                o_cmd.div_start = r_go;
                if (i_stat.div_done) begin
                    o_cmd.wr_res = 1'b1;
                    n_state      = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_stat.out_full) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_go    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_go    <= n_go;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// ===== sv/variable_step_derivatives.sv =====
`timescale 1ns / 1ps
// channel  dir  payload                                        handshake
// i_in     in   position, step_time, restart                   valid / ready
// o_out    out  velocity, acceleration, jerk, saturated        valid / ready
//
// one word at a time: each derivative in turn takes the shared 3-bit-per-cycle divider,
// a first sample of a path skips the divider and gives zero results
// reset (i_rst_n, synchronous) clears the path history, the next word starts a path
// a new word is taken while the previous result still waits in the output register
// a stalled o_out holds the finished word back before the history is updated

module variable_step_derivatives import vsd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    vsd_in_if.sink    i_in,
    vsd_out_if.source o_out
);

    t_cmd  cmd;
    t_stat stat;

    vsd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    vsd_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_position     (i_in.position),
        .i_step_time    (i_in.step_time),
        .i_restart      (i_in.restart),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_velocity     (o_out.velocity),
        .o_acceleration (o_out.acceleration),
        .o_jerk         (o_out.jerk),
        .o_saturated    (o_out.saturated)
    );

endmodule

// ===== dv/variable_step_derivatives_check.sv =====
`timescale 1ns / 1ps

module variable_step_derivatives_check import vsd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    vsd_in_if    i_in_ch,
    vsd_out_if   i_out_ch,
    output int   o_fail_count,
    output int   o_pending
);

    localparam longint Q_SCALE = 64'sd65536;
    localparam longint Q_HI    = 64'sd2147483647;
    localparam longint Q_LO    = -64'sd2147483648;
    localparam int     SHOWN   = 10;

    typedef struct packed {
        logic signed [POS_W-1:0] velocity;
        logic signed [POS_W-1:0] acceleration;
        logic signed [POS_W-1:0] jerk;
        logic                    saturated;
    } t_derivs;

    t_derivs                 expected_derivs[$];
    int                      errors = 0;

    logic signed [POS_W-1:0] last_pos   = '0;
    logic        [STEP_W-1:0] last_step = '0;
    logic signed [POS_W-1:0] last_vel   = '0;
    logic signed [POS_W-1:0] last_acc   = '0;
    logic        [CNT_W-1:0] path_count = '0;

    // {clipped, value}
    function automatic logic [POS_W:0] clamp_q(input longint v);
        if (v > Q_HI) begin
            return {1'b1, Q_MAX};
        end else if (v < Q_LO) begin
            return {1'b1, Q_MIN};
        end
        return {1'b0, v[POS_W-1:0]};
    endfunction

    function automatic t_derivs derive_sample(input logic signed [POS_W-1:0] pos,
                                              input logic [STEP_W-1:0] st,
                                              input logic rs);
        logic        [CNT_W-1:0]  n;
        logic        [STEP_W-1:0] s;
        logic signed [POS_W-1:0]  vel;
        logic signed [POS_W-1:0]  acc;
        logic signed [POS_W-1:0]  jrk;
        logic                     sat;
        logic        [POS_W:0]    c;
        longint                   diff;
        t_derivs                  r;
        n   = rs ? '0 : path_count;
        s   = (st == '0) ? STEP_LSB : st;
        vel = '0;
        acc = '0;
        jrk = '0;
        sat = 1'b0;
        if (n >= 1) begin
            diff = longint'(pos) - longint'(last_pos);
            c    = clamp_q((diff * Q_SCALE) / longint'(s));
            vel  = c[POS_W-1:0];
            sat  = sat | c[POS_W];
        end
        if (n >= 2) begin
            diff = longint'(vel) - longint'(last_vel);
            c    = clamp_q((diff * 2 * Q_SCALE) / (longint'(s) + longint'(last_step)));
            acc  = c[POS_W-1:0];
            sat  = sat | c[POS_W];
        end
        if (n >= 3) begin
            diff = longint'(acc) - longint'(last_acc);
            c    = clamp_q((diff * Q_SCALE) / longint'(last_step));
            jrk  = c[POS_W-1:0];
            sat  = sat | c[POS_W];
        end
        last_pos   = pos;
        last_step  = s;
        last_vel   = vel;
        last_acc   = acc;
        path_count = (n == CNT_FULL) ? CNT_FULL : n + 1'b1;
        r.velocity     = vel;
        r.acceleration = acc;
        r.jerk         = jrk;
        r.saturated    = sat;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_derivs want;
        t_derivs got;
        if (!i_rst_n) begin
            last_pos   = '0;
            last_step  = '0;
            last_vel   = '0;
            last_acc   = '0;
            path_count = '0;
        end else begin
            if (i_in_ch.valid && i_in_ch.ready) begin
                expected_derivs.push_back(derive_sample(i_in_ch.position, i_in_ch.step_time,
                                                        i_in_ch.restart));
            end
            if (i_out_ch.valid && i_out_ch.ready) begin
                got.velocity     = i_out_ch.velocity;
                got.acceleration = i_out_ch.acceleration;
                got.jerk         = i_out_ch.jerk;
                got.saturated    = i_out_ch.saturated;
                if (expected_derivs.size() == 0) begin
                    if (errors < SHOWN) begin
                        $display("unexpected word: vel %0d acc %0d jerk %0d sat %0b",
                                 got.velocity, got.acceleration, got.jerk, got.saturated);
                    end
                    errors++;
                end else begin
                    want = expected_derivs.pop_front();
                    if (got.velocity !== want.velocity
                            || got.acceleration !== want.acceleration
                            || got.jerk !== want.jerk
                            || got.saturated !== want.saturated) begin
                        if (errors < SHOWN) begin
                            $display("mismatch: expected vel %0d acc %0d jerk %0d sat %0b",
                                     want.velocity, want.acceleration, want.jerk,
                                     want.saturated);
                            $display("          got      vel %0d acc %0d jerk %0d sat %0b",
                                     got.velocity, got.acceleration, got.jerk, got.saturated);
                        end
                        errors++;
                    end
                end
            end
        end
        o_fail_count <= errors;
        o_pending    <= expected_derivs.size();
    end

endmodule

// ===== dv/variable_step_derivatives_test.sv =====
`timescale 1ns / 1ps

module variable_step_derivatives_test;
    import vsd_pkg::*;

    localparam int RANDOM_WORDS   = 1400;
    localparam int CALM_WORDS     = 200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 60;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   quiet_cycles = 0;
    int   gap_odds     = 0;
    int   stall_odds   = 0;

    vsd_in_if  in_ch();
    vsd_out_if out_ch();

    variable_step_derivatives DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    variable_step_derivatives_check deriv_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_ch      (in_ch),
        .i_out_ch     (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // result side back-pressure
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    function automatic logic [STEP_W-1:0] pick_step();
        int r;
        r = $urandom_range(0, 63);
        if (r == 0) begin
            return '0;
        end else if (r <= 6) begin
            return STEP_W'($urandom_range(1, 8));
        end else if (r <= 10) begin
            return '1;
        end else if (r <= 24) begin
            return STEP_W'($urandom_range(1, 65535));
        end
        return STEP_W'($urandom_range(200, 8000));
    endfunction

    task automatic send_word(input logic signed [POS_W-1:0] pos, input logic [STEP_W-1:0] st,
                             input logic rs);
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.position  <= pos;
        in_ch.step_time <= st;
        in_ch.restart   <= rs;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    initial begin
        logic signed [POS_W-1:0] pos;
        logic        [STEP_W-1:0] st;
        longint                   delta;
        int                       vel_q;
        int                       jolt;
        int                       len;
        int                       sent;
        logic                     first_rs;
        in_ch.valid     <= 1'b0;
        in_ch.position  <= '0;
        in_ch.step_time <= '0;
        in_ch.restart   <= 1'b0;
        i_rst_n         <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes, saturation, zero step, restarts
        send_word(32'sh0000_0000, 16'd1, 1'b0);
        send_word(32'sh7FFF_FFFF, 16'd1, 1'b0);
        send_word(32'sh8000_0000, 16'd1, 1'b0);
        send_word(32'sh7FFF_FFFF, 16'hFFFF, 1'b0);
        send_word(32'sh0000_0000, 16'd0, 1'b0);
        send_word(32'sh0000_0000, 16'hFFFF, 1'b1);
        send_word(32'sh0001_0000, 16'hFFFF, 1'b0);
        send_word(32'sh0002_0000, 16'd0, 1'b0);
        send_word(32'sh0000_0000, 16'd1, 1'b0);
        send_word(32'sh0000_0000, 16'd1, 1'b0);
        send_word(32'sh7FFF_FFFF, 16'd0, 1'b1);
        send_word(32'sh8000_0000, 16'h8000, 1'b0);
        send_word(32'sh0000_0001, 16'd1, 1'b0);
        send_word(-32'sd1, 16'd2, 1'b0);
        send_word(32'sd0, 16'd6554, 1'b1);
        send_word(32'sd1000, 16'd6554, 1'b0);
        send_word(32'sd4000, 16'd6554, 1'b0);
        send_word(32'sd9000, 16'd6554, 1'b0);
        send_word(32'sd16000, 16'd6554, 1'b0);
        send_word(32'sd100, 16'd100, 1'b1);
        send_word(32'sd200, 16'd100, 1'b1);
        send_word(32'sd300, 16'd100, 1'b0);

        sent = 0;
        while (sent < RANDOM_WORDS) begin
            if (sent >= RANDOM_WORDS - CALM_WORDS) begin
                gap_odds   = 0;
                stall_odds = 0;
            end else begin
                case ($urandom_range(0, 2))
                    0: gap_odds = 0;
                    1: gap_odds = 3;
                    default: gap_odds = 8;
                endcase
                case ($urandom_range(0, 2))
                    0: stall_odds = 0;
                    1: stall_odds = 3;
                    default: stall_odds = 8;
                endcase
            end
            len = $urandom_range(1, 40);
            if ($urandom_range(0, 3) == 0) begin
                // unstructured samples with stray restarts
                for (int i = 0; i < len; i++) begin
                    send_word($urandom, pick_step(), $urandom_range(0, 7) == 0);
                    sent++;
                end
            end else begin
                // smooth path with random drift in velocity
                case ($urandom_range(0, 2))
                    0: jolt = 16;
                    1: jolt = 4096;
                    default: jolt = 1 << 18;
                endcase
                pos      = $urandom;
                vel_q    = int'($urandom_range(0, 1 << 21)) - (1 << 20);
                first_rs = ($urandom_range(0, 7) != 0);
                for (int i = 0; i < len; i++) begin
                    st    = pick_step();
                    vel_q = vel_q + int'($urandom_range(0, 2 * jolt)) - jolt;
                    delta = (longint'(vel_q) * longint'(st)) >>> 16;
                    pos   = pos + delta[POS_W-1:0];
                    send_word(pos, st, (i == 0) ? first_rs : 1'b0);
                    sent++;
                end
            end
        end
        in_ch.valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
